### rtl/core/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// shared types and constants of the text console cursor and scroll engine
// ----------------------------------------------------------------------------
package tcc_pkg;

	// default geometry of the cell store
	localparam int MAX_COLUMNS_DEF = 80;
	localparam int MAX_ROWS_DEF    = 25;

	// field widths
	localparam int ColW   = 7;
	localparam int RowW   = 5;
	localparam int AreaW  = ColW + RowW;
	localparam int CellW  = 16;
	localparam int CharW  = 8;
	localparam int AddrInW = 11;

	// register reset values
	localparam logic [ColW-1:0] COLUMN_COUNT_RST = 7'd80;
	localparam logic [RowW-1:0] ROW_COUNT_RST    = 5'd25;

	// configuration register indexes
	localparam logic REG_COLUMN_COUNT = 1'b0;
	localparam logic REG_ROW_COUNT    = 1'b1;

	// operation codes
	localparam logic FUNC_PUT  = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	// control bytes
	localparam logic [CharW-1:0] CH_NUL = 8'd0;
	localparam logic [CharW-1:0] CH_BS  = 8'd8;
	localparam logic [CharW-1:0] CH_LF  = 8'd10;
	localparam logic [CharW-1:0] CH_CR  = 8'd13;

	// cell contents
	localparam logic [CellW-1:0] BLANK_CELL = 16'h0720;
	localparam logic [7:0]       TEXT_ATTR  = 8'h07;

	// active screen geometry as seen by the sequencer
	typedef struct packed {
		logic [ColW-1:0]  cols;       // clamped column count
		logic [RowW-1:0]  rows;       // clamped row count
		logic [AreaW-1:0] area;       // rows * cols
		logic [AreaW-1:0] last_base;  // (rows - 1) * cols
	} geometry_t;

	// sequencer status toward the top level
	typedef struct packed {
		logic busy;       // no new transaction taken
		logic fin;        // result goes out after this cycle
		logic take_data;  // result carries the read cell
	} seq_status_t;

endpackage

### rtl/core/tcc_cell_mem.sv
// ----------------------------------------------------------------------------
// tcc_cell_mem
// screen cell store, one write port and one registered read port
// ----------------------------------------------------------------------------
module tcc_cell_mem #(
	parameter int Depth = tcc_pkg::MAX_COLUMNS_DEF * tcc_pkg::MAX_ROWS_DEF,
	parameter int AW    = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [tcc_pkg::CellW-1:0] wdata,
	input  logic [AW-1:0]            raddr,
	output logic [tcc_pkg::CellW-1:0] rdata
);

	logic [tcc_pkg::CellW-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/tcc_seq.sv
// ----------------------------------------------------------------------------
// tcc_seq
// sequencer: store clearing, scroll copy and fill, character put, cell read
// ----------------------------------------------------------------------------
module tcc_seq #(
	parameter int MaxColumns = tcc_pkg::MAX_COLUMNS_DEF,
	parameter int MaxRows    = tcc_pkg::MAX_ROWS_DEF,
	parameter int Depth      = MaxColumns * MaxRows,
	parameter int AW         = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        func,
	input  logic [tcc_pkg::CharW-1:0]   char_code,
	input  logic [tcc_pkg::AddrInW-1:0] cell_address,
	input  tcc_pkg::geometry_t          geo,
	output tcc_pkg::seq_status_t        status,
	output logic                        mem_we,
	output logic [AW-1:0]               mem_waddr,
	output logic [tcc_pkg::CellW-1:0]   mem_wdata,
	output logic [AW-1:0]               mem_raddr,
	input  logic [tcc_pkg::CellW-1:0]   mem_rdata,
	output logic [tcc_pkg::ColW-1:0]    cursor_column,
	output logic [tcc_pkg::RowW-1:0]    cursor_row
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_COPY  = 3'd2;
	localparam logic [2:0] ST_FILL  = 3'd3;
	localparam logic [2:0] ST_PUT   = 3'd4;
	localparam logic [2:0] ST_RDOUT = 3'd5;

	logic [2:0]                     state_q;
	logic [AW-1:0]                  clr_q;
	logic [tcc_pkg::AreaW-1:0]      scan_q;
	logic [tcc_pkg::AreaW-1:0]      fill_q;
	logic [tcc_pkg::ColW-1:0]       cursor_x_q;
	logic [tcc_pkg::RowW-1:0]       cursor_y_q;
	logic [tcc_pkg::CharW-1:0]      ch_q;
	logic                           addr_ok_q;
	logic                           pend_s1;
	logic [tcc_pkg::AreaW-1:0]      dst_s1;

	logic                           accept;
	logic                           printable;
	logic [tcc_pkg::ColW-1:0]       col_lim;
	logic [tcc_pkg::ColW-1:0]       col_next;
	logic [tcc_pkg::AreaW-1:0]      put_addr;

	assign accept = start && (state_q == ST_IDLE);

	assign status.busy      = (state_q != ST_IDLE);
	assign status.fin       = (state_q == ST_PUT) || (state_q == ST_RDOUT);
	assign status.take_data = (state_q == ST_RDOUT) && addr_ok_q;

	assign cursor_column = cursor_x_q;
	assign cursor_row    = cursor_y_q;

	// put address: cursor clamped to the last column
	always_comb begin
		printable = !(ch_q inside {tcc_pkg::CH_NUL, tcc_pkg::CH_BS, tcc_pkg::CH_LF,
			tcc_pkg::CH_CR});
		col_lim   = (cursor_x_q < geo.cols) ? cursor_x_q : geo.cols - 7'd1;
		col_next  = col_lim + 7'd1;
		put_addr  = tcc_pkg::AreaW'(cursor_y_q) * tcc_pkg::AreaW'(geo.cols)
			+ tcc_pkg::AreaW'(col_lim);
	end

	// write port: a pending copy write wins, fill stalls behind it
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(fill_q);
		mem_wdata = tcc_pkg::BLANK_CELL;
		if (pend_s1) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(dst_s1);
			mem_wdata = mem_rdata;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					mem_we    = 1'b1;
					mem_waddr = clr_q;
				end
				ST_FILL: begin
					mem_we = 1'b1;
				end
				ST_PUT: begin
					mem_we    = printable;
					mem_waddr = AW'(put_addr);
					mem_wdata = {tcc_pkg::TEXT_ATTR, ch_q};
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end
	end

	// reads run ahead of copy writes, so a row is never read after it is overwritten
	assign mem_raddr = (state_q == ST_IDLE) ? AW'(cell_address) : AW'(scan_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			scan_q     <= '0;
			fill_q     <= '0;
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			pend_s1    <= 1'b0;
		end else begin
			pend_s1 <= (state_q == ST_COPY);
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(Depth - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (func == tcc_pkg::FUNC_READ) begin
							state_q <= ST_RDOUT;
						end else if (char_code != tcc_pkg::CH_NUL
							&& cursor_y_q >= geo.rows) begin
							if (geo.rows == 5'd1) begin
								fill_q  <= '0;
								state_q <= ST_FILL;
							end else begin
								scan_q  <= tcc_pkg::AreaW'(geo.cols);
								state_q <= ST_COPY;
							end
						end else begin
							state_q <= ST_PUT;
						end
					end
				end
				ST_COPY: begin
					if (scan_q == geo.area - 1'b1) begin
						fill_q  <= geo.last_base;
						state_q <= ST_FILL;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_FILL: begin
					if (!pend_s1) begin
						if (fill_q == geo.area - 1'b1) begin
							cursor_y_q <= geo.rows - 5'd1;
							state_q    <= ST_PUT;
						end else begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				ST_PUT: begin
					state_q <= ST_IDLE;
					case (ch_q)
						tcc_pkg::CH_NUL: begin
						end
						tcc_pkg::CH_BS: begin
							if (cursor_x_q != '0) begin
								cursor_x_q <= cursor_x_q - 7'd1;
							end
						end
						tcc_pkg::CH_CR: begin
							cursor_x_q <= '0;
						end
						tcc_pkg::CH_LF: begin
							cursor_x_q <= '0;
							cursor_y_q <= cursor_y_q + 5'd1;
						end
						default: begin
							if (col_next >= geo.cols) begin
								cursor_x_q <= '0;
								cursor_y_q <= cursor_y_q + 5'd1;
							end else begin
								cursor_x_q <= col_next;
							end
						end
					endcase
				end
				ST_RDOUT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// transaction payload and copy pipeline
	always_ff @(posedge clk) begin
		dst_s1 <= scan_q - tcc_pkg::AreaW'(geo.cols);
		if (accept) begin
			ch_q      <= char_code;
			addr_ok_q <= (32'(cell_address) < 32'(Depth));
		end
	end

`ifndef SYNTH
	a_scroll_entered: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == tcc_pkg::FUNC_PUT && char_code != tcc_pkg::CH_NUL
			&& cursor_y_q >= geo.rows)
		|=> (state_q == ST_COPY || state_q == ST_FILL))
		else $error("pending scroll not started");

	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUT && $past(state_q) == ST_FILL)
		|-> (cursor_y_q == geo.rows - 5'd1))
		else $error("cursor row wrong after scroll");

	a_copy_order: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (dst_s1 < scan_q))
		else $error("copy write not behind read");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_s1)
		else $error("copy write pending while idle");
`endif

endmodule

### rtl/core/text_console_cursor_scroll.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// text-mode screen engine: cell store, cursor and one-row scrolling
// ----------------------------------------------------------------------------
// After reset the block clears all MAX_COLUMNS*MAX_ROWS cells to blank, one cell
// a cycle, with busy high; configuration writes are taken during that pass. A
// transaction is taken when start is high and busy is low. For a read or a put
// the result is on cell_data, cursor_column and cursor_row while done is high for
// one cycle, and busy is low again in that same cycle, so the next transaction
// can follow at once. The receiver cannot stall the block and must take each
// result as it comes. A put of any byte but NUL that finds the cursor row at or
// past the row count first scrolls the store: the single memory port pair copies
// one cell a cycle up by one row, then blanks the bottom row once the last copy
// write is done; with one row it only blanks that row. The cursor row is then the
// last row and the put goes on.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll #(
	parameter int MAX_COLUMNS = tcc_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = tcc_pkg::MAX_ROWS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// command channel
	input  logic                        start,
	output logic                        busy,
	input  logic                        func,
	input  logic [tcc_pkg::CharW-1:0]   char_code,
	input  logic [tcc_pkg::AddrInW-1:0] cell_address,
	// result channel
	output logic                        done,
	output logic [tcc_pkg::CellW-1:0]   cell_data,
	output logic [tcc_pkg::ColW-1:0]    cursor_column,
	output logic [tcc_pkg::RowW-1:0]    cursor_row,
	// configuration write port
	input  logic                        cfg_write,
	input  logic                        cfg_index,
	input  logic [tcc_pkg::ColW-1:0]    cfg_data
);

	localparam int Depth = MAX_COLUMNS * MAX_ROWS;
	localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

	// configuration registers as written
	logic [tcc_pkg::ColW-1:0]  column_count_q;
	logic [tcc_pkg::RowW-1:0]  row_count_q;

	// clamped geometry; area terms are registered behind the multipliers
	logic [tcc_pkg::ColW-1:0]  cols_act;
	logic [tcc_pkg::RowW-1:0]  rows_act;
	logic [tcc_pkg::AreaW-1:0] area_q;
	logic [tcc_pkg::AreaW-1:0] last_base_q;
	tcc_pkg::geometry_t        geo;
	tcc_pkg::seq_status_t      status;

	// result registers
	logic                      done_q;
	logic [tcc_pkg::CellW-1:0] cell_data_q;

	// memory connections
	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic [tcc_pkg::CellW-1:0] mem_wdata;
	logic [AW-1:0]             mem_raddr;
	logic [tcc_pkg::CellW-1:0] mem_rdata;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= tcc_pkg::COLUMN_COUNT_RST;
			row_count_q    <= tcc_pkg::ROW_COUNT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				tcc_pkg::REG_COLUMN_COUNT: column_count_q <= cfg_data;
				tcc_pkg::REG_ROW_COUNT:    row_count_q    <= cfg_data[tcc_pkg::RowW-1:0];
				default: begin
				end
			endcase
		end
	end

	// zero acts as one, anything past the store acts as the store size
	always_comb begin
		if (column_count_q == '0) begin
			cols_act = 7'd1;
		end else if (int'(column_count_q) > MAX_COLUMNS) begin
			cols_act = tcc_pkg::ColW'(MAX_COLUMNS);
		end else begin
			cols_act = column_count_q;
		end
		if (row_count_q == '0) begin
			rows_act = 5'd1;
		end else if (int'(row_count_q) > MAX_ROWS) begin
			rows_act = tcc_pkg::RowW'(MAX_ROWS);
		end else begin
			rows_act = row_count_q;
		end
	end

	// area terms are used only from the cycle after a transaction is taken
	always_ff @(posedge clk) begin
		area_q      <= tcc_pkg::AreaW'(rows_act) * tcc_pkg::AreaW'(cols_act);
		last_base_q <= tcc_pkg::AreaW'(rows_act - 5'd1) * tcc_pkg::AreaW'(cols_act);
	end

	assign geo.cols      = cols_act;
	assign geo.rows      = rows_act;
	assign geo.area      = area_q;
	assign geo.last_base = last_base_q;

	tcc_seq #(
		.MaxColumns (MAX_COLUMNS),
		.MaxRows    (MAX_ROWS),
		.Depth      (Depth),
		.AW         (AW)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.func          (func),
		.char_code     (char_code),
		.cell_address  (cell_address),
		.geo           (geo),
		.status        (status),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata),
		.cursor_column (cursor_column),
		.cursor_row    (cursor_row)
	);

	tcc_cell_mem #(
		.Depth (Depth),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// result strobe; puts and out-of-range reads report a zero cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= status.fin;
		end
	end

	always_ff @(posedge clk) begin
		cell_data_q <= status.take_data ? mem_rdata : '0;
	end

	assign busy      = status.busy;
	assign done      = done_q;
	assign cell_data = cell_data_q;

endmodule
